// ----- rtl/sorted_priority_queue_core_assert.svh -----
// Assertion macros used by the sorted priority queue core.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/spq_pkg.sv -----
// Types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 8;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_APPEND = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef struct packed {
        t_action                  action;
        logic [PAYLOAD_BITS-1:0]  item_payload;
        logic [PRIORITY_BITS-1:0] item_priority;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic [PAYLOAD_BITS-1:0]  out_payload;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic                     is_empty;
        logic                     is_full;
    } t_result;

    typedef struct packed {
        logic                     valid;
        logic [PRIORITY_BITS-1:0] priority_val;
        logic [PAYLOAD_BITS-1:0]  payload;
    } t_entry;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the queue chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_op    i_op,
    input  spq_pkg::t_entry i_new,
    input  spq_pkg::t_entry i_left,
    input  spq_pkg::t_entry i_right,
    input  logic           i_found,
    output logic           o_found,
    output spq_pkg::t_entry o_entry
);

    logic                              r_valid;
    logic                              n_valid;
    logic [spq_pkg::PRIORITY_BITS-1:0] r_pri;
    logic [spq_pkg::PRIORITY_BITS-1:0] n_pri;
    logic [spq_pkg::PAYLOAD_BITS-1:0]  r_pay;
    logic [spq_pkg::PAYLOAD_BITS-1:0]  n_pay;
    logic                              w_match;

    always_comb begin
        // This slot is the insertion point if it is free or outranked by the new entry.
        w_match = !r_valid || (i_op == spq_pkg::OP_INSERT && r_pri >= i_new.priority_val);
        o_found = i_found || w_match;
        n_valid = r_valid;
        n_pri   = r_pri;
        n_pay   = r_pay;
        case (i_op)
            spq_pkg::OP_APPEND, spq_pkg::OP_INSERT: begin
                if (i_found) begin
                    // shift toward the tail
                    n_valid = i_left.valid;
                    n_pri   = i_left.priority_val;
                    n_pay   = i_left.payload;
                end else if (w_match) begin
                    n_valid = 1'b1;
                    n_pri   = i_new.priority_val;
                    n_pay   = i_new.payload;
                end
            end
            spq_pkg::OP_REMOVE: begin
                // advance toward the head
                n_valid = i_right.valid;
                n_pri   = i_right.priority_val;
                n_pay   = i_right.payload;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_pay <= n_pay;
    end

    assign o_entry = '{valid: r_valid, priority_val: r_pri, payload: r_pay};

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
// Sorted priority queue: a chain of entry cells with command and result handling.
//
// Usage: drive i_cmd and raise i_start; the command is taken at any clock edge with
// i_start high and o_busy low. o_busy stays low, so one command is taken every cycle.
// Actions: append at the tail, insert ahead of the first entry whose priority is
// greater than or equal, or remove the head. Head is slot 0 of the cell chain.
// Every command gives one result on o_result, marked by o_done for exactly one
// cycle, on the cycle after the command is taken (throughput 1 per cycle).
// All cells compare against the broadcast command and shift in the same cycle, while
// the insertion search ripples through the chain.
// Status reports an empty queue on remove or a full queue on append or insert; such
// commands leave the contents as they were. is_empty and is_full give the state
// after the command.
// Reset empties the queue at once (valid flags only) and drops any pending result.
// The receiver cannot stall: a result not captured in its cycle is gone.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_assert.svh"
module sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  spq_pkg::t_cmd    i_cmd,
    output logic            o_busy,
    output logic            o_done,
    output spq_pkg::t_result o_result
);

    localparam spq_pkg::t_entry EMPTY_ENTRY = '{valid: 1'b0, priority_val: '0, payload: '0};

    spq_pkg::t_entry  w_entry [CAPACITY];
    logic             w_found [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    spq_pkg::t_entry  w_new;
    spq_pkg::t_op     w_op;
    logic             w_accept;
    spq_pkg::t_result n_result;
    spq_pkg::t_result r_result;
    logic             r_done;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_new    = '{valid: 1'b1, priority_val: i_cmd.item_priority,
                        payload: i_cmd.item_payload};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_found_in;
        if (g == 0) begin : g_head
            assign w_left     = EMPTY_ENTRY;
            assign w_found_in = 1'b0;
        end else begin : g_body
            assign w_left     = w_entry[g-1];
            assign w_found_in = w_found[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = EMPTY_ENTRY;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .i_found (w_found_in),
            .o_found (w_found[g]),
            .o_entry (w_entry[g])
        );
        assign w_valid[g] = w_entry[g].valid;
    end

    always_comb begin
        w_op                  = spq_pkg::OP_HOLD;
        n_result.status       = spq_pkg::ST_DONE;
        n_result.out_payload  = '0;
        n_result.out_priority = '0;
        n_result.is_empty     = !w_valid[0];
        n_result.is_full      = w_valid[CAPACITY-1];
        case (i_cmd.action)
            spq_pkg::ACT_APPEND, spq_pkg::ACT_INSERT: begin
                if (w_valid[CAPACITY-1]) begin
                    n_result.status = spq_pkg::ST_FULL;
                end else begin
                    w_op = (i_cmd.action == spq_pkg::ACT_APPEND) ? spq_pkg::OP_APPEND
                                                                 : spq_pkg::OP_INSERT;
                    n_result.is_empty = 1'b0;
                    n_result.is_full  = w_valid[CAPACITY-2];
                end
            end
            spq_pkg::ACT_REMOVE: begin
                if (!w_valid[0]) begin
                    n_result.status = spq_pkg::ST_EMPTY;
                end else begin
                    w_op                  = spq_pkg::OP_REMOVE;
                    n_result.out_payload  = w_entry[0].payload;
                    n_result.out_priority = w_entry[0].priority_val;
                    n_result.is_empty     = !w_valid[1];
                    n_result.is_full      = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // drop the operation unless a transaction is taken
        if (!w_accept) begin
            w_op = spq_pkg::OP_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `SPQ_ASSERT_NOW(a_valid_packed, 1'b1, ((w_valid >> 1) & ~w_valid) == '0,
        "occupied slots are not contiguous from the head")
    `SPQ_ASSERT_NEXT(a_done_follows, w_accept, o_done, "accepted transaction gave no result")
    `SPQ_ASSERT_NEXT(a_no_spurious, !w_accept, !o_done, "result without a transaction")
    `SPQ_ASSERT_NEXT(a_empty_remove,
        w_accept && i_cmd.action == spq_pkg::ACT_REMOVE && !w_valid[0],
        o_result.status == spq_pkg::ST_EMPTY && !w_valid[0],
        "remove from empty queue misreported or changed contents")
    `SPQ_ASSERT_NEXT(a_add_not_empty,
        w_accept && (i_cmd.action == spq_pkg::ACT_APPEND
            || i_cmd.action == spq_pkg::ACT_INSERT) && !w_valid[CAPACITY-1],
        w_valid[0] && !o_result.is_empty, "added entry left queue empty")

endmodule
